>>> hdl/actc_pkg.sv
package actc_pkg;

   localparam int TABLE_POINTS = 512;
   localparam int BIN_BITS     = $clog2(TABLE_POINTS);
   localparam int ANGLE_BITS   = 16;
   localparam int FRAC_BITS    = ANGLE_BITS - BIN_BITS;
   localparam int CURRENT_BITS = 16;
   localparam int SUM_BITS     = 32;
   localparam int CNT_BITS     = 16;
   localparam int FF_BITS      = 17;
   localparam int AVG_BITS     = CURRENT_BITS + 1;
   localparam int TOTAL_BITS   = AVG_BITS + BIN_BITS;

   typedef enum logic [1:0] {
      KIND_BEGIN  = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_FINISH = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_DONE   = 2'd0,
      STAT_OK     = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_IGNORE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_CALIB = 2'd1,
      MODE_READY = 2'd2
   } mode_type;

endpackage

>>> hdl/actc_div.sv
module actc_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [actc_pkg::SUM_BITS-1:0]   dividend,
   input  logic        [actc_pkg::CNT_BITS-1:0]   divisor,
   output logic                                   done,
   output logic signed [actc_pkg::AVG_BITS-1:0]   quotient
);

   localparam int STEP_BITS = $clog2(actc_pkg::SUM_BITS + 1);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [STEP_BITS-1:0]            step_ff, step_in;
   logic [actc_pkg::CNT_BITS:0]     rem_ff, rem_in;
   logic [actc_pkg::SUM_BITS-1:0]   quo_ff, quo_in;
   logic [actc_pkg::CNT_BITS-1:0]   den_ff, den_in;
   logic                            neg_ff, neg_in;
   logic [actc_pkg::CNT_BITS:0]     rem_sh;
   logic [actc_pkg::CNT_BITS:0]     rem_sub;
   logic [actc_pkg::SUM_BITS-1:0]   quo_sgn;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff[actc_pkg::CNT_BITS-1:0], quo_ff[actc_pkg::SUM_BITS-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         neg_in  = dividend[actc_pkg::SUM_BITS-1];
         quo_in  = dividend[actc_pkg::SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub;
            quo_in = {quo_ff[actc_pkg::SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[actc_pkg::SUM_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(actc_pkg::SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   assign quo_sgn  = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient = quo_sgn[actc_pkg::AVG_BITS-1:0];
   assign done     = done_ff;

endmodule

>>> hdl/anticogging_table_calibrator_unit.sv
// Anti-cogging table: 512 bins held in two single-port-read synchronous memories (sums and
// counts). A sample reads its bin, then writes back sum and count (dropped once the count
// saturates); a query reads two neighboring bins in turn and interpolates between them.
// Begin clears both memories, one bin a cycle, before its result is registered; the same
// clearing pass runs after reset, during which no item is taken. Finish walks the counts
// (answering empty at the first bin with a zero count), then divides every bin with a serial
// divider, then subtracts the mean from every bin. Only one item is in work at a time; the
// next is taken as soon as its result is registered, even while that result waits on rsp_tready.
module anticogging_table_calibrator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // angle[15:0], current_sample[31:16]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // feedforward[16:0], zero[23:17]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int BB = actc_pkg::BIN_BITS;
   localparam int FB = actc_pkg::FRAC_BITS;
   localparam int SB = actc_pkg::SUM_BITS;
   localparam int CB = actc_pkg::CNT_BITS;
   localparam int FF = actc_pkg::FF_BITS;
   localparam int AB = actc_pkg::AVG_BITS;
   localparam int TB = actc_pkg::TOTAL_BITS;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_CLEAR = 10'b0000000010,
      ST_SMP   = 10'b0000000100,
      ST_Q1    = 10'b0000001000,
      ST_Q2    = 10'b0000010000,
      ST_CHK   = 10'b0000100000,
      ST_DRD   = 10'b0001000000,
      ST_DRUN  = 10'b0010000000,
      ST_SRD   = 10'b0100000000,
      ST_RESP  = 10'b1000000000
   } state_type;

   logic signed [SB-1:0] sum_mem [actc_pkg::TABLE_POINTS];
   logic        [CB-1:0] cnt_mem [actc_pkg::TABLE_POINTS];

   state_type                state_ff, state_in;
   actc_pkg::mode_type       mode_ff, mode_in;
   logic                     pend_ff, pend_in;
   logic [BB-1:0]            idx_ff, idx_in;
   logic [actc_pkg::ANGLE_BITS-1:0]   angle_ff, angle_in;
   logic signed [actc_pkg::CURRENT_BITS-1:0] cur_ff, cur_in;
   logic signed [FF-1:0]     t0_ff, t0_in;
   logic signed [TB-1:0]     total_ff, total_in;
   logic signed [FF-1:0]     res_ff_ff, res_ff_in;
   actc_pkg::status_type     res_st_ff, res_st_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [FF-1:0]     rsp_ff_ff, rsp_ff_in;
   actc_pkg::status_type     rsp_st_ff, rsp_st_in;
   logic signed [SB-1:0]     sum_q_ff;
   logic        [CB-1:0]     cnt_q_ff;

   logic [BB-1:0]            rd_addr;
   logic                     sum_we, cnt_we;
   logic [BB-1:0]            wr_addr;
   logic signed [SB-1:0]     wr_sum;
   logic [CB-1:0]            wr_cnt;
   logic                     div_start, div_done;
   logic signed [AB-1:0]     div_q;

   logic                     accept;
   actc_pkg::kind_type       kind;
   logic [actc_pkg::ANGLE_BITS-1:0] req_angle;
   logic [BB-1:0]            req_bin, bin;
   logic [FB-1:0]            frac;
   logic signed [FF:0]       diff;
   logic signed [FF+FB+1:0]  prod;
   logic signed [FF+1:0]     interp;
   logic signed [FF-1:0]     mean;

   assign accept    = req_tvalid && req_tready;
   assign kind      = actc_pkg::kind_type'(req_tuser);
   assign req_angle = req_tdata[actc_pkg::ANGLE_BITS-1:0];
   assign req_bin   = req_angle[actc_pkg::ANGLE_BITS-1 -: BB];
   assign bin       = angle_ff[actc_pkg::ANGLE_BITS-1 -: BB];
   assign frac      = angle_ff[FB-1:0];
   assign diff      = {sum_q_ff[FF-1], sum_q_ff[FF-1:0]} - {t0_ff[FF-1], t0_ff};
   assign prod      = diff * $signed({1'b0, frac});
   assign interp    = {{2{t0_ff[FF-1]}}, t0_ff} + prod[FF+FB+1:FB];
   // floor of total / TABLE_POINTS
   assign mean      = total_ff[TB-1:BB];

   actc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_q_ff),
      .divisor  (cnt_q_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pend_in      = pend_ff;
      idx_in       = idx_ff;
      angle_in     = angle_ff;
      cur_in       = cur_ff;
      t0_in        = t0_ff;
      total_in     = total_ff;
      res_ff_in    = res_ff_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ff_in    = rsp_ff_ff;
      rsp_st_in    = rsp_st_ff;
      rd_addr      = idx_ff;
      sum_we       = 1'b0;
      cnt_we       = 1'b0;
      wr_addr      = idx_ff;
      wr_sum       = '0;
      wr_cnt       = '0;
      div_start    = 1'b0;
      req_tready   = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               angle_in  = req_angle;
               cur_in    = req_tdata[16 +: actc_pkg::CURRENT_BITS];
               res_ff_in = '0;
               res_st_in = actc_pkg::STAT_DONE;
               rd_addr   = req_bin;
               unique case (kind)
                  actc_pkg::KIND_BEGIN: begin
                     mode_in  = actc_pkg::MODE_CALIB;
                     pend_in  = 1'b1;
                     idx_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  actc_pkg::KIND_SAMPLE: begin
                     if (mode_ff == actc_pkg::MODE_CALIB) begin
                        state_in = ST_SMP;
                     end else begin
                        res_st_in = actc_pkg::STAT_IGNORE;
                        state_in  = ST_RESP;
                     end
                  end
                  actc_pkg::KIND_FINISH: begin
                     if (mode_ff == actc_pkg::MODE_CALIB) begin
                        idx_in   = '0;
                        rd_addr  = '0;
                        state_in = ST_CHK;
                     end else begin
                        res_st_in = actc_pkg::STAT_IGNORE;
                        state_in  = ST_RESP;
                     end
                  end
                  actc_pkg::KIND_QUERY: begin
                     if (mode_ff == actc_pkg::MODE_READY) begin
                        state_in = ST_Q1;
                     end else begin
                        res_st_in = actc_pkg::STAT_IGNORE;
                        state_in  = ST_RESP;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR: begin
            sum_we = 1'b1;
            cnt_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (&idx_ff) begin
               state_in = pend_ff ? ST_RESP : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_SMP: begin
            // drop the sample once the bin count saturates
            wr_addr = bin;
            if (cnt_q_ff != {CB{1'b1}}) begin
               sum_we = 1'b1;
               cnt_we = 1'b1;
               wr_sum = sum_q_ff + SB'(cur_ff);
               wr_cnt = cnt_q_ff + 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_Q1: begin
            t0_in    = sum_q_ff[FF-1:0];
            rd_addr  = bin + 1'b1;
            state_in = ST_Q2;
         end
         ST_Q2: begin
            res_ff_in = interp[FF-1:0];
            state_in  = ST_RESP;
         end
         ST_CHK: begin
            if (cnt_q_ff == '0) begin
               mode_in   = actc_pkg::MODE_IDLE;
               res_st_in = actc_pkg::STAT_EMPTY;
               state_in  = ST_RESP;
            end else if (&idx_ff) begin
               idx_in   = '0;
               rd_addr  = '0;
               total_in = '0;
               state_in = ST_DRD;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end
         ST_DRD: begin
            div_start = 1'b1;
            state_in  = ST_DRUN;
         end
         ST_DRUN: begin
            rd_addr = idx_ff + 1'b1;
            if (div_done) begin
               sum_we   = 1'b1;
               wr_sum   = SB'(div_q);
               total_in = total_ff + TB'(div_q);
               idx_in   = idx_ff + 1'b1;
               state_in = (&idx_ff) ? ST_SRD : ST_DRD;
            end
         end
         ST_SRD: begin
            sum_we  = 1'b1;
            wr_sum  = sum_q_ff - SB'(mean);
            idx_in  = idx_ff + 1'b1;
            rd_addr = idx_ff + 1'b1;
            if (&idx_ff) begin
               mode_in   = actc_pkg::MODE_READY;
               res_st_in = actc_pkg::STAT_OK;
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ff_in    = res_ff_ff;
               rsp_st_in    = res_st_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mode_ff      <= actc_pkg::MODE_IDLE;
         pend_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      angle_ff  <= angle_in;
      cur_ff    <= cur_in;
      t0_ff     <= t0_in;
      total_ff  <= total_in;
      res_ff_ff <= res_ff_in;
      res_st_ff <= res_st_in;
      rsp_ff_ff <= rsp_ff_in;
      rsp_st_ff <= rsp_st_in;
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[wr_addr] <= wr_sum;
      end
      sum_q_ff <= sum_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
      cnt_q_ff <= cnt_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24 - FF){1'b0}}, rsp_ff_ff};
   assign rsp_tuser  = rsp_st_ff;

endmodule

>>> verif/tb_anticogging_table_calibrator_unit.sv
`timescale 1ns / 1ps

module tb_anticogging_table_calibrator_unit;

   localparam longint CYCLE_LIMIT = 3_000_000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   anticogging_table_calibrator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   typedef struct packed {
      logic signed [actc_pkg::FF_BITS-1:0] feedforward;
      actc_pkg::status_type                status;
   } comp_result_type;

   class cogging_table_scoreboard_type;
      actc_pkg::mode_type mode;
      bit                 enabled;
      longint             sums[actc_pkg::TABLE_POINTS];
      bit [15:0]          counts[actc_pkg::TABLE_POINTS];
      comp_result_type    pending[$];
      int                 errors;

      function void clear_bins();
         for (int i = 0; i < actc_pkg::TABLE_POINTS; i++) begin
            sums[i]   = 0;
            counts[i] = '0;
         end
      endfunction

      function new();
         mode    = actc_pkg::MODE_IDLE;
         enabled = 1'b0;
         errors  = 0;
         clear_bins();
      endfunction

      function actc_pkg::status_type finish_table();
         longint total;
         longint mean;
         total = 0;
         if (mode != actc_pkg::MODE_CALIB) return actc_pkg::STAT_IGNORE;
         for (int i = 0; i < actc_pkg::TABLE_POINTS; i++) begin
            if (counts[i] == 0) begin
               mode = actc_pkg::MODE_IDLE;
               return actc_pkg::STAT_EMPTY;
            end
         end
         for (int i = 0; i < actc_pkg::TABLE_POINTS; i++) begin
            sums[i] = sums[i] / longint'(counts[i]);
            total += sums[i];
         end
         mean = total >>> actc_pkg::BIN_BITS;
         for (int i = 0; i < actc_pkg::TABLE_POINTS; i++) sums[i] -= mean;
         mode    = actc_pkg::MODE_READY;
         enabled = 1'b1;
         return actc_pkg::STAT_OK;
      endfunction

      function void note_input(actc_pkg::kind_type kind, logic [15:0] angle,
                               logic signed [15:0] cur);
         comp_result_type r;
         int              b;
         int              b1;
         longint          frac;
         longint          t0;
         longint          t1;
         longint          ff;
         b  = int'(angle >> actc_pkg::FRAC_BITS);
         b1 = (b + 1) % actc_pkg::TABLE_POINTS;
         ff = 0;
         r.status = actc_pkg::STAT_DONE;
         case (kind)
            actc_pkg::KIND_BEGIN: begin
               clear_bins();
               enabled = 1'b0;
               mode    = actc_pkg::MODE_CALIB;
            end
            actc_pkg::KIND_SAMPLE: begin
               if (mode != actc_pkg::MODE_CALIB) r.status = actc_pkg::STAT_IGNORE;
               else if (counts[b] != 16'hFFFF) begin
                  sums[b]   += longint'(cur);
                  counts[b] = counts[b] + 16'd1;
               end
            end
            actc_pkg::KIND_FINISH: r.status = finish_table();
            default: begin
               if (mode != actc_pkg::MODE_READY || !enabled) r.status = actc_pkg::STAT_IGNORE;
               else begin
                  frac = longint'(angle[actc_pkg::FRAC_BITS-1:0]) << actc_pkg::BIN_BITS;
                  t0   = sums[b];
                  t1   = sums[b1];
                  ff   = t0 + (((t1 - t0) * frac) >>> actc_pkg::ANGLE_BITS);
               end
            end
         endcase
         r.feedforward = ff[actc_pkg::FF_BITS-1:0];
         pending.push_back(r);
      endfunction

      function void check_result(logic [actc_pkg::FF_BITS-1:0] ff, logic [1:0] status);
         comp_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result: feedforward %0d status %0d", $signed(ff), status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (ff !== e.feedforward) begin
            $error("feedforward: expected %0d, got %0d", e.feedforward, $signed(ff));
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
         end
      endfunction
   endclass

   cogging_table_scoreboard_type table_sb;
   bit     no_idle;
   int     rsp_stall;
   longint cycle_count = 0;

   initial clock = 0;
   always #5 clock = ~clock;

   function automatic int pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, 2));
      return int'($urandom_range(3, 40));
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // hold tready low for random stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 3) == 0) rsp_stall <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            table_sb.note_input(actc_pkg::kind_type'(req_tuser), req_tdata[15:0],
                                req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready)
            table_sb.check_result(rsp_tdata[actc_pkg::FF_BITS-1:0], rsp_tuser);
      end
   end

   task automatic send(actc_pkg::kind_type kind, logic [15:0] angle, logic [15:0] cur);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {cur, angle};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (table_sb.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_current();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 200)) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] bin_angle(int b);
      return 16'((b << actc_pkg::FRAC_BITS) |
                 $urandom_range(0, (1 << actc_pkg::FRAC_BITS) - 1));
   endfunction

   // visit every bin except skip_bin once in shuffled order, with a few stray items mixed in
   task automatic fill_bins(int skip_bin);
      int order[actc_pkg::TABLE_POINTS];
      int j;
      int t;
      for (int i = 0; i < actc_pkg::TABLE_POINTS; i++) order[i] = i;
      for (int i = actc_pkg::TABLE_POINTS - 1; i > 0; i--) begin
         j = int'($urandom_range(0, i));
         t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (int i = 0; i < actc_pkg::TABLE_POINTS; i++) begin
         if (order[i] != skip_bin)
            send(actc_pkg::KIND_SAMPLE, bin_angle(order[i]), rand_current());
         case ($urandom_range(0, 39))
            0: send(actc_pkg::KIND_QUERY, 16'($urandom), 16'($urandom));
            1: send(actc_pkg::KIND_SAMPLE, 16'($urandom), rand_current());
            default: ;
         endcase
      end
   endtask

   task automatic run_queries(int n);
      send(actc_pkg::KIND_QUERY, 16'h0000, 16'h0000);
      send(actc_pkg::KIND_QUERY, 16'hFFFF, 16'hFFFF);
      send(actc_pkg::KIND_QUERY, 16'hFF80, 16'h0000);
      send(actc_pkg::KIND_QUERY, 16'h007F, 16'h0000);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            send(actc_pkg::KIND_SAMPLE, 16'($urandom), 16'($urandom));
         else send(actc_pkg::KIND_QUERY, 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      table_sb    = new();
      no_idle     = 0;
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tuser   = actc_pkg::KIND_BEGIN;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // wrong-mode items, an empty-bin finish, and the field extremes
      send(actc_pkg::KIND_QUERY,  16'h1234, 16'h0000);
      send(actc_pkg::KIND_SAMPLE, 16'h0000, 16'h7FFF);
      send(actc_pkg::KIND_FINISH, 16'hFFFF, 16'hFFFF);
      send(actc_pkg::KIND_BEGIN,  16'hFFFF, 16'h8000);
      send(actc_pkg::KIND_QUERY,  16'h0000, 16'h0000);
      send(actc_pkg::KIND_SAMPLE, 16'h0000, 16'h8000);
      send(actc_pkg::KIND_SAMPLE, 16'hFFFF, 16'h7FFF);
      send(actc_pkg::KIND_SAMPLE, 16'h5555, 16'hAAAA);
      send(actc_pkg::KIND_SAMPLE, 16'hAAAA, 16'h5555);
      drain();
      send(actc_pkg::KIND_FINISH, 16'h0000, 16'h0000);
      send(actc_pkg::KIND_FINISH, 16'h0000, 16'h0000);
      send(actc_pkg::KIND_SAMPLE, 16'h0100, 16'h0001);
      send(actc_pkg::KIND_QUERY,  16'h0100, 16'h0000);

      // full calibration with idling on both sides
      send(actc_pkg::KIND_BEGIN, 16'($urandom), 16'($urandom));
      fill_bins(-1);
      drain();
      send(actc_pkg::KIND_FINISH, 16'($urandom), 16'($urandom));
      run_queries(20);
      send(actc_pkg::KIND_FINISH, 16'($urandom), 16'($urandom));

      // begin while ready, then a finish with most bins never sampled
      send(actc_pkg::KIND_BEGIN, 16'($urandom), 16'($urandom));
      for (int i = 0; i < 12; i++)
         send(actc_pkg::KIND_SAMPLE, 16'($urandom), rand_current());
      send(actc_pkg::KIND_FINISH, 16'($urandom), 16'($urandom));
      send(actc_pkg::KIND_QUERY,  16'($urandom), 16'($urandom));

      req_tvalid <= 1'b0;
      while (table_sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
